[hdl/mctb_pkg.sv]
// ----------------------------------------------------------------------------
// mctb_pkg
// Shared types and constants of the multi-channel timer bank.
// ----------------------------------------------------------------------------
package mctb_pkg;

    localparam int COUNT_W     = 16;
    localparam int OUT_IDX_W   = 6;
    localparam int MAX_REPORTS = 8;
    localparam int REP_W       = 4;

    // Request codes carried in the low bits of the input beat.
    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_SCAN  = 3'd1,
        REQ_START = 3'd2,
        REQ_STOP  = 3'd3,
        REQ_CLEAR = 3'd4,
        REQ_LOAD  = 3'd5
    } t_req;

    // One channel entry as held in the state memory.
    typedef struct packed {
        logic               run;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] limit;
    } t_chan;

    // One expiry report handed from the sequencer to the output register.
    typedef struct packed {
        logic                 valid;
        logic [OUT_IDX_W-1:0] idx;
        logic                 last;
    } t_push;

endpackage

[hdl/mctb_mem.sv]
// ----------------------------------------------------------------------------
// mctb_mem
// Channel state memory: one write and one registered read port, with a
// valid bit per entry so that unwritten channels read as all zero.
// ----------------------------------------------------------------------------
module mctb_mem
    import mctb_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_re,
    input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] i_raddr,
    input  logic  i_we,
    input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] i_waddr,
    input  t_chan i_wdata,
    output t_chan o_rdata
);

    t_chan                   r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_vld;
    t_chan                   r_rdata;
    logic                    r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    // A channel never written since reset holds its reset value, all zero.
    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

[hdl/mctb_seq.sv]
// ----------------------------------------------------------------------------
// mctb_seq
// Request sequencer: single-channel read-modify-write for start, stop,
// clear and load, and a pipelined walk over all channels for tick and scan.
// ----------------------------------------------------------------------------
module mctb_seq
    import mctb_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_req               i_req,
    input  logic [7:0]         i_timer_index,
    input  logic [COUNT_W-1:0] i_limit_value,
    input  logic [COUNT_W-1:0] i_initial_count,
    input  logic               i_enable_bit,
    output logic               o_re,
    output logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] o_raddr,
    output logic               o_we,
    output logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] o_waddr,
    output t_chan              o_wdata,
    input  t_chan              i_rdata,
    output t_push              o_push,
    input  logic               i_out_ready
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CW = $clog2(NUM_CHANNELS + 1);
    localparam logic [CW-1:0] CH_END   = CW'(NUM_CHANNELS);
    localparam logic [8:0]    IDX_END  = 9'(NUM_CHANNELS);
    localparam logic [REP_W-1:0] REP_LAST = REP_W'(MAX_REPORTS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RMW   = 4'b0010,
        S_WALK  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    t_req                 r_req,   n_req;
    logic [AW-1:0]        r_idx,   n_idx;
    logic [COUNT_W-1:0]   r_lim,   n_lim;
    logic [COUNT_W-1:0]   r_init,  n_init;
    logic                 r_en,    n_en;
    logic [CW-1:0]        r_ch,    n_ch;
    logic                 r_dv,    n_dv;
    logic [AW-1:0]        r_pch,   n_pch;
    logic [REP_W-1:0]     r_nrep,  n_nrep;
    logic                 r_pv,    n_pv;
    logic [OUT_IDX_W-1:0] r_pidx,  n_pidx;

    logic hit, is_scan, stall, stop, in_range;

    assign o_ready  = (r_state == S_IDLE);
    assign in_range = ({1'b0, i_timer_index} < IDX_END);
    assign is_scan  = (r_req == REQ_SCAN);
    assign hit      = i_rdata.run && (i_rdata.count >= i_rdata.limit);
    // A new expiry pushes the held one out, so it waits for a free output.
    assign stall    = r_dv && is_scan && hit && r_pv && !i_out_ready;
    assign stop     = r_dv && is_scan && hit && (r_nrep == REP_LAST);

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_idx   = r_idx;
        n_lim   = r_lim;
        n_init  = r_init;
        n_en    = r_en;
        n_ch    = r_ch;
        n_dv    = r_dv;
        n_pch   = r_pch;
        n_nrep  = r_nrep;
        n_pv    = r_pv;
        n_pidx  = r_pidx;
        o_re    = 1'b0;
        o_raddr = r_ch[AW-1:0];
        o_we    = 1'b0;
        o_waddr = r_pch;
        o_wdata = i_rdata;
        o_push  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req  = i_req;
                    n_idx  = i_timer_index[AW-1:0];
                    n_lim  = i_limit_value;
                    n_init = i_initial_count;
                    n_en   = i_enable_bit;
                    case (i_req)
                        REQ_TICK, REQ_SCAN: begin
                            n_state = S_WALK;
                            n_ch    = '0;
                            n_dv    = 1'b0;
                            n_nrep  = '0;
                            n_pv    = 1'b0;
                        end
                        REQ_START, REQ_STOP, REQ_CLEAR, REQ_LOAD: begin
                            if (in_range) begin
                                o_re    = 1'b1;
                                o_raddr = i_timer_index[AW-1:0];
                                n_state = S_RMW;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RMW: begin
                o_we    = 1'b1;
                o_waddr = r_idx;
                case (r_req)
                    REQ_START: o_wdata.run   = 1'b1;
                    REQ_STOP:  o_wdata.run   = 1'b0;
                    REQ_CLEAR: o_wdata.count = '0;
                    REQ_LOAD: begin
                        o_wdata.run   = r_en;
                        o_wdata.count = r_init;
                        o_wdata.limit = r_lim;
                    end
                    default: begin
                    end
                endcase
                n_state = S_IDLE;
            end
            S_WALK: begin
                if (!stall) begin
                    if (r_dv) begin
                        if (is_scan) begin
                            if (hit) begin
                                o_we          = 1'b1;
                                o_wdata.count = '0;
                                o_push.valid  = r_pv;
                                o_push.idx    = r_pidx;
                                o_push.last   = 1'b0;
                                n_pv          = 1'b1;
                                n_pidx        = OUT_IDX_W'(r_pch);
                                n_nrep        = r_nrep + 1'b1;
                            end
                        end else if (i_rdata.run && (i_rdata.count != '1)) begin
                            o_we          = 1'b1;
                            o_wdata.count = i_rdata.count + 1'b1;
                        end
                    end
                    if (!stop && (r_ch < CH_END)) begin
                        o_re  = 1'b1;
                        n_pch = r_ch[AW-1:0];
                        n_ch  = r_ch + 1'b1;
                        n_dv  = 1'b1;
                    end else begin
                        n_dv    = 1'b0;
                        n_state = is_scan ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (i_out_ready) begin
                    o_push.valid = 1'b1;
                    o_push.idx   = r_pidx;
                    o_push.last  = 1'b1;
                    n_pv         = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_idx  <= n_idx;
        r_lim  <= n_lim;
        r_init <= n_init;
        r_en   <= n_en;
        r_ch   <= n_ch;
        r_pch  <= n_pch;
        r_nrep <= n_nrep;
        r_pidx <= n_pidx;
    end

endmodule

[hdl/multi_channel_timer_bank.sv]
// ----------------------------------------------------------------------------
// multi_channel_timer_bank
// Bank of periodic timer channels with tick, scan and per-channel commands.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  --------  ---------  -----------------------------------------------------
//  s (req)   in         tdata: req_type, timer_index, limit_value,
//                              initial_count, enable_bit
//  m (rpt)   out        tdata: expired_index; tlast: last_flag
//
//  A start, stop, clear or load does one memory read, then one write.
//  Out-of-range indexes and unused request codes take no memory access.
//  A tick or scan walks the channels through the single read port, one per
//  cycle while the walk is not stalled. A scan ends early after MAX_REPORTS
//  reports, and always passes a flush state to hand over any final report.
//  Reset clears the per-entry valid bits at once; no clearing pass is needed.
//  A full output register only holds the walk when a new expiry must push
//  the previously found report out.
//
module multi_channel_timer_bank
    import mctb_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [2:0] req_type, [10:3] timer_index, [26:11] limit_value,
    // [42:27] initial_count, [43] enable_bit, [47:44] zero
    input  logic [47:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [5:0] expired_index, [7:6] zero
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic          mem_re, mem_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    t_chan         mem_wdata, mem_rdata;
    t_push         push;
    logic          out_ready;

    // Output register: one report beat parts the walk from the consumer.
    logic                 r_ovalid;
    logic [OUT_IDX_W-1:0] r_oidx;
    logic                 r_olast;

    // The output register can take a report when it is empty or draining.
    assign out_ready = !r_ovalid || i_m_tready;

    mctb_seq #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_req          (t_req'(i_s_tdata[2:0])),
        .i_timer_index  (i_s_tdata[10:3]),
        .i_limit_value  (i_s_tdata[26:11]),
        .i_initial_count(i_s_tdata[42:27]),
        .i_enable_bit   (i_s_tdata[43]),
        .o_re           (mem_re),
        .o_raddr        (mem_raddr),
        .o_we           (mem_we),
        .o_waddr        (mem_waddr),
        .o_wdata        (mem_wdata),
        .i_rdata        (mem_rdata),
        .o_push         (push),
        .i_out_ready    (out_ready)
    );

    mctb_mem #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push.valid) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push.valid) begin
            r_oidx  <= push.idx;
            r_olast <= push.last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_oidx};
    assign o_m_tlast  = r_olast;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-channel timer bank.
// ----------------------------------------------------------------------------
// Request beats go in on the slave stream and expiry reports come out on the
// master stream. The bench models the channel bank on its own and checks
// every report beat, in order, against a queue of predicted reports.
// A short directed table covers reset state, zero limits, saturation, stopped
// channels, ignored indexes and request codes, and a full scan. A random
// phase follows, with bursty input traffic and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
    import mctb_pkg::*;

    localparam int NUM_CH       = 8;
    localparam int N_RANDOM     = 184;
    localparam int PAUSE_AT     = 100;
    localparam int CYCLE_LIMIT  = 200000;
    // Drain time after the last request, enough for a walk over every channel.
    localparam int DRAIN_CYCLES = 2 * NUM_CH + 8;

    // Request codes that the block must ignore.
    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    // One expiry report: channel index and end-of-scan marker.
    typedef struct packed {
        logic [OUT_IDX_W-1:0] idx;
        logic                 last;
    } t_rpt;

    // One row of request stimulus. When hand_typed is set, the reports are
    // given in the row itself (none, or a single one with the given index).
    typedef struct {
        logic [2:0]         req;
        logic [7:0]         idx;
        logic [COUNT_W-1:0] lim;
        logic [COUNT_W-1:0] init;
        logic               en;
        bit                 hand_typed;
        int                 n_rep;
        logic [5:0]         rep_idx;
    } t_req_row;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        o_s_tready;
    // [2:0] req_type, [10:3] timer_index, [26:11] limit_value,
    // [42:27] initial_count, [43] enable_bit, [47:44] zero
    logic [47:0] s_tdata  = '0;
    logic        o_m_tvalid;
    logic        m_tready = 1'b0;
    // [5:0] expired_index, [7:6] zero
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;

    // Our own copy of the channel bank, updated on every accepted request.
    logic               chan_run   [NUM_CH] = '{default: 1'b0};
    logic [COUNT_W-1:0] chan_count [NUM_CH] = '{default: '0};
    logic [COUNT_W-1:0] chan_limit [NUM_CH] = '{default: '0};

    t_rpt     pending_reports[$];
    t_req_row directed_reqs[$];
    int       mismatch_cnt = 0;
    int       cycle_cnt    = 0;
    int       burst_left   = 0;
    t_rpt     head_rpt;

    multi_channel_timer_bank #(
        .NUM_CHANNELS (NUM_CH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Prints one line per mismatch and keeps the count for the verdict.
    task automatic report_err(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    function automatic t_req_row mk_row(input logic [2:0] req, input logic [7:0] idx,
                                        input logic [15:0] lim, input logic [15:0] init,
                                        input logic en, input bit hand_typed,
                                        input int n_rep, input logic [5:0] rep_idx);
        t_req_row r;
        r.req        = req;
        r.idx        = idx;
        r.lim        = lim;
        r.init       = init;
        r.en         = en;
        r.hand_typed = hand_typed;
        r.n_rep      = n_rep;
        r.rep_idx    = rep_idx;
        return r;
    endfunction

    // Applies one request to the bank copy and returns the reports it causes.
    function automatic void bank_step(input t_req_row r, output int n,
                                      output t_rpt reps[MAX_REPORTS]);
        n = 0;
        for (int k = 0; k < MAX_REPORTS; k++) reps[k] = '0;
        case (r.req)
            REQ_TICK: begin
                for (int c = 0; c < NUM_CH; c++)
                    if (chan_run[c] && chan_count[c] != 16'hFFFF)
                        chan_count[c] = chan_count[c] + 16'd1;
            end
            REQ_SCAN: begin
                // Index order, and no more than MAX_REPORTS reports per scan.
                for (int c = 0; c < NUM_CH && n < MAX_REPORTS; c++) begin
                    if (chan_run[c] && chan_count[c] >= chan_limit[c]) begin
                        chan_count[c] = '0;
                        reps[n].idx   = OUT_IDX_W'(c);
                        reps[n].last  = 1'b0;
                        n++;
                    end
                end
                if (n > 0) reps[n-1].last = 1'b1;
            end
            default: begin
                if (r.idx < NUM_CH) begin
                    case (r.req)
                        REQ_START: chan_run[r.idx] = 1'b1;
                        REQ_STOP:  chan_run[r.idx] = 1'b0;
                        REQ_CLEAR: chan_count[r.idx] = '0;
                        REQ_LOAD: begin
                            chan_limit[r.idx] = r.lim;
                            chan_count[r.idx] = r.init;
                            chan_run[r.idx]   = r.en;
                        end
                        default: ;
                    endcase
                end
            end
        endcase
    endfunction

    // Drives one request beat. Called at a falling edge; returns at the
    // falling edge after the beat was accepted. Between bursts the sender
    // drops valid for a random idle gap, or not at all.
    task automatic send_req(input t_req_row r);
        int   gap;
        int   n;
        t_rpt reps[MAX_REPORTS];
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            // Now and then a long burst with no idle cycles at all.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, r.en, r.init, r.lim, r.idx, r.req};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        // The beat is accepted at this edge: predict its reports.
        bank_step(r, n, reps);
        if (r.hand_typed) begin
            if (r.n_rep > 0) pending_reports.push_back('{idx: r.rep_idx, last: 1'b1});
        end else begin
            for (int k = 0; k < n; k++) pending_reports.push_back(reps[k]);
        end
        @(negedge i_clk);
    endtask

    // Random request with a bias toward short limits, so that scans find
    // expiries often, and with occasional counts near saturation.
    function automatic t_req_row rand_row();
        t_req_row r;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 28)      r.req = REQ_TICK;
        else if (roll < 48) r.req = REQ_SCAN;
        else if (roll < 58) r.req = REQ_START;
        else if (roll < 66) r.req = REQ_STOP;
        else if (roll < 72) r.req = REQ_CLEAR;
        else if (roll < 94) r.req = REQ_LOAD;
        else if (roll < 97) r.req = REQ_RSVD6;
        else                r.req = REQ_RSVD7;
        r.idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NUM_CH, 255))
                                            : 8'($urandom_range(0, NUM_CH - 1));
        r.lim = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        case ($urandom_range(0, 5))
            0:       r.init = 16'($urandom);
            1:       r.init = 16'($urandom_range(16'hFFFD, 16'hFFFF));
            default: r.init = 16'($urandom_range(0, 3));
        endcase
        r.en         = ($urandom_range(0, 3) != 0);
        r.hand_typed = 1'b0;
        r.n_rep      = 0;
        r.rep_idx    = '0;
        // Fields that tick and scan ignore carry random noise.
        if (r.req == REQ_TICK || r.req == REQ_SCAN) begin
            r.idx  = 8'($urandom);
            r.lim  = 16'($urandom);
            r.init = 16'($urandom);
            r.en   = 1'($urandom);
        end
        return r;
    endfunction

    // Receiver: stretches of always-ready, light stalls and heavy stalls.
    initial begin
        int mode;
        int len;
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(4, 40);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 99) < 50);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Report checker: every accepted report beat must match the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                report_err($sformatf("unpredicted report idx %0d last %0b",
                                     o_m_tdata[5:0], o_m_tlast));
            end else begin
                head_rpt = pending_reports.pop_front();
                if (o_m_tdata[5:0] !== head_rpt.idx)
                    report_err($sformatf("expired_index %0d, predicted %0d",
                                         o_m_tdata[5:0], head_rpt.idx));
                if (o_m_tlast !== head_rpt.last)
                    report_err($sformatf("last_flag %0b, predicted %0b (idx %0d)",
                                         o_m_tlast, head_rpt.last, head_rpt.idx));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        // Directed table. Rows marked as hand typed carry their reports in
        // the row; all other rows are checked against the bank model.
        // Right after reset every channel is stopped: nothing expires.
        directed_reqs.push_back(mk_row(REQ_SCAN,  8'd0,   16'h0000, 16'h0000, 1'b0, 1, 0, 0));
        directed_reqs.push_back(mk_row(REQ_TICK,  8'd0,   16'h0000, 16'h0000, 1'b0, 1, 0, 0));
        directed_reqs.push_back(mk_row(REQ_SCAN,  8'd0,   16'h0000, 16'h0000, 1'b0, 1, 0, 0));
        // A running channel with a zero limit expires on every scan.
        directed_reqs.push_back(mk_row(REQ_LOAD,  8'd0,   16'h0000, 16'h0000, 1'b1, 1, 0, 0));
        directed_reqs.push_back(mk_row(REQ_SCAN,  8'd0,   16'h0000, 16'h0000, 1'b0, 1, 1, 6'd0));
        // Top channel at full-scale limit, counted into saturation.
        directed_reqs.push_back(mk_row(REQ_LOAD,  8'd7,   16'hFFFF, 16'hFFFE, 1'b1, 1, 0, 0));
        directed_reqs.push_back(mk_row(REQ_TICK,  8'd0,   16'h0000, 16'h0000, 1'b0, 0, 0, 0));
        directed_reqs.push_back(mk_row(REQ_TICK,  8'd0,   16'h0000, 16'h0000, 1'b0, 0, 0, 0));
        directed_reqs.push_back(mk_row(REQ_SCAN,  8'd0,   16'h0000, 16'h0000, 1'b0, 0, 0, 0));
        // Indexes outside the bank and unused request codes change nothing.
        directed_reqs.push_back(mk_row(REQ_LOAD,  8'd8,   16'h0000, 16'h0000, 1'b1, 1, 0, 0));
        directed_reqs.push_back(mk_row(REQ_LOAD,  8'd255, 16'h0000, 16'hFFFF, 1'b1, 1, 0, 0));
        directed_reqs.push_back(mk_row(REQ_RSVD6, 8'd1,   16'h0000, 16'h0000, 1'b1, 1, 0, 0));
        directed_reqs.push_back(mk_row(REQ_RSVD7, 8'd2,   16'hFFFF, 16'hFFFF, 1'b1, 1, 0, 0));
        directed_reqs.push_back(mk_row(REQ_START, 8'd200, 16'h0000, 16'h0000, 1'b0, 1, 0, 0));
        // A stopped channel neither counts nor expires, and keeps its count.
        directed_reqs.push_back(mk_row(REQ_STOP,  8'd0,   16'h0000, 16'h0000, 1'b0, 0, 0, 0));
        directed_reqs.push_back(mk_row(REQ_TICK,  8'd0,   16'h0000, 16'h0000, 1'b0, 0, 0, 0));
        directed_reqs.push_back(mk_row(REQ_SCAN,  8'd0,   16'h0000, 16'h0000, 1'b0, 1, 0, 0));
        directed_reqs.push_back(mk_row(REQ_START, 8'd0,   16'h0000, 16'h0000, 1'b0, 0, 0, 0));
        directed_reqs.push_back(mk_row(REQ_CLEAR, 8'd7,   16'h0000, 16'h0000, 1'b0, 0, 0, 0));
        // Every channel expires in one scan: a full run of reports.
        for (int c = 1; c < NUM_CH; c++)
            directed_reqs.push_back(mk_row(REQ_LOAD, 8'(c), 16'h0000, 16'(c), 1'b1, 0, 0, 0));
        directed_reqs.push_back(mk_row(REQ_SCAN,  8'd0,   16'h0000, 16'h0000, 1'b0, 0, 0, 0));

        // Reset is held from the start and released at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_reqs[k]) send_req(directed_reqs[k]);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == PAUSE_AT) begin
                // Hold the sender until the report stream has run dry.
                s_tvalid <= 1'b0;
                @(negedge i_clk);
                while (pending_reports.size() != 0) @(negedge i_clk);
            end
            send_req(rand_row());
        end
        s_tvalid <= 1'b0;

        // Let the last walk finish and catch any stray report beats.
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
